/* rtl/ert_pkg.sv */
package ert_pkg;

	localparam int NUM_SOCKETS = 1024;
	localparam int SOCK_W = $clog2(NUM_SOCKETS);
	localparam int LINK_W = SOCK_W + 1;
	localparam int MAX_BURST = 64;
	localparam int MAXE_W = 7;
	localparam int CNT_W = $clog2(NUM_SOCKETS + 1);
	localparam logic [31:0] EPOLLERR = 32'h0000_0008;
	localparam logic [31:0] EPOLLHUP = 32'h0000_0010;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_DEL = 3'd1;
	localparam logic [2:0] MODE_MOD = 3'd2;
	localparam logic [2:0] MODE_NOTIFY = 3'd3;
	localparam logic [2:0] MODE_WAIT = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EXISTS = 2'd1;
	localparam logic [1:0] ST_NOREG = 2'd2;
	localparam logic [1:0] ST_MERGED = 2'd3;

	localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_SOCKETS);

	// entry word: mask, data, next, prev
	localparam int ENT_W = 32 + 64 + 2 * LINK_W;

	typedef struct packed {
		logic [31:0] mask;
		logic [63:0] data;
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
	} entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic [SOCK_W-1:0] sock;
		logic [31:0] events;
		logic [63:0] data;
		logic has;
		logic last;
	} result_t;

endpackage

/* rtl/event_ready_table_unit.sv */
// event ready table: interest table with a last-in-first-out ready list
// input channel s_axis: tdata = mode, sock_id, event_mask, user_data, max_events
// output channel m_axis: tdata = status, out_sock, out_events, out_data, has_entry;
// tlast marks the final result of one input transfer
// one item is processed at a time; entries live in a ram and the registered and
// ready flags in a second ram, both with a registered read port
// every result is registered from the step that makes it, and the input is
// ready again after the output handoff, once the output register is free
// add, modify, notify on a ready entry and any failed operation: result from the
// entry read step, then the output handoff
// notify push onto a non-empty list and delete of a ready entry: result after
// the read and fix of the neighbor links
// wait: first result from the head entry read, then one popped entry per pass
// through the pop, the fix of the new head's prev link and the output handoff
// after reset the flag ram is cleared with s_axis_tready low; head is empty and
// counts are zero
// a stalled receiver holds the output register; the sequencer waits for it
module event_ready_table_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// mode[2:0] sock_id[12:3] event_mask[44:13] user_data[108:45] max_events[115:109]
	input logic [119:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[1:0] out_sock[11:2] out_events[43:12] out_data[107:44] has_entry[108]
	output logic [111:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import ert_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;   // entry read data valid
	localparam logic [2:0] S_NB_RD = 3'd2; // neighbor read issued
	localparam logic [2:0] S_NB2_RD = 3'd3;
	localparam logic [2:0] S_WAIT_RD = 3'd4; // head entry read issued
	localparam logic [2:0] S_WAIT_NB = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] mode_q;
	logic [SOCK_W-1:0] sock_q;
	logic [31:0] ev_q;
	logic [63:0] data_q;
	logic [MAXE_W-1:0] left_q;
	logic [LINK_W-1:0] head_q;
	logic [CNT_W-1:0] rcount_q, regcount_q;
	entry_t ent_q; // entry being worked on
	logic [2:0] ret_q; // state after output handoff
	logic [SOCK_W-1:0] cur_q;

	// ram
	logic ram_we;
	logic [SOCK_W-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;
	ert_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SOCKETS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic fl_we, fl_reg_i, fl_rdy_i, fl_reg, fl_rdy, fl_busy;
	logic [SOCK_W-1:0] fl_raddr, fl_waddr;
	ert_flags u_flags (
		.clk(clk), .arst_n(arst_n), .busy(fl_busy), .raddr(fl_raddr), .reg_o(fl_reg),
		.rdy_o(fl_rdy), .we(fl_we), .waddr(fl_waddr), .reg_i(fl_reg_i), .rdy_i(fl_rdy_i)
	);

	// output register
	result_t out_q;
	logic ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {3'b0, out_q.has, out_q.data, out_q.events, out_q.sock,
		out_q.status};
	assign m_axis_tlast = out_q.last;
	logic ofree;
	assign ofree = !ovalid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE) && ofree && !fl_busy;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [2:0] in_mode;
	logic [SOCK_W-1:0] in_sock;
	logic [MAXE_W-1:0] in_maxe, maxe_sat;
	assign in_mode = s_axis_tdata[2:0];
	assign in_sock = s_axis_tdata[12:3];
	assign in_maxe = s_axis_tdata[115:109];
	always_comb begin
		maxe_sat = in_maxe;
		if (in_maxe == '0) maxe_sat = MAXE_W'(1);
		if (in_maxe > MAXE_W'(MAX_BURST)) maxe_sat = MAXE_W'(MAX_BURST);
	end

	// combinational control
	logic emit;
	result_t emit_r;
	logic [2:0] nstate;
	logic [SOCK_W-1:0] hd;
	assign hd = head_q[SOCK_W-1:0];

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sock_q;
		ram_wdata = ent_q;
		ram_raddr = in_sock;
		fl_we = 1'b0;
		fl_waddr = sock_q;
		fl_reg_i = fl_reg;
		fl_rdy_i = fl_rdy;
		fl_raddr = in_sock;
		emit = 1'b0;
		emit_r = '0;
		emit_r.last = 1'b1;
		nstate = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (in_mode == MODE_WAIT) begin
						ram_raddr = s_axis_tdata[12:3];
						nstate = S_WAIT_RD;
					end else nstate = S_RD;
					if (in_mode == MODE_WAIT) ram_raddr = hd;
				end
			end
			S_RD: begin
				// flags of sock_q, ram data of sock_q
				nstate = S_OUT;
				emit = 1'b1;
				ram_wdata = ram_rdata;
				if (mode_q > MODE_WAIT || mode_q == MODE_WAIT) begin
					emit_r.status = ST_OK;
				end else if (mode_q == MODE_ADD) begin
					if (fl_reg) emit_r.status = ST_EXISTS;
					else begin
						ram_we = 1'b1;
						ram_wdata.mask = ev_q;
						ram_wdata.data = data_q;
						fl_we = 1'b1;
						fl_reg_i = 1'b1;
						fl_rdy_i = 1'b0;
					end
				end else if (!fl_reg) begin
					emit_r.status = ST_NOREG;
				end else if (mode_q == MODE_DEL) begin
					fl_we = 1'b1;
					fl_reg_i = 1'b0;
					fl_rdy_i = 1'b0;
					if (fl_rdy) begin
						// unlink: fix prev's next, then next's prev
						emit = 1'b0;
						nstate = S_NB_RD;
						if (ram_rdata.prev != LINK_END)
							ram_raddr = ram_rdata.prev[SOCK_W-1:0];
					end
				end else if (mode_q == MODE_MOD) begin
					ram_we = 1'b1;
					ram_wdata.mask = ev_q | EPOLLERR | EPOLLHUP;
				end else begin
					if (fl_rdy) begin
						ram_we = 1'b1;
						ram_wdata.mask = ram_rdata.mask | ev_q;
						emit_r.status = ST_MERGED;
					end else begin
						ram_we = 1'b1;
						ram_wdata.next = head_q;
						ram_wdata.prev = LINK_END;
						fl_we = 1'b1;
						fl_rdy_i = 1'b1;
						if (head_q != LINK_END) begin
							emit = 1'b0;
							ram_raddr = hd;
							nstate = S_NB2_RD;
						end
					end
				end
			end
			S_NB_RD: begin
				// delete unlink, ent_q holds deleted entry links
				if (ent_q.prev != LINK_END) begin
					ram_we = 1'b1;
					ram_waddr = ent_q.prev[SOCK_W-1:0];
					ram_wdata = ram_rdata;
					ram_wdata.next = ent_q.next;
				end
				if (ent_q.next != LINK_END) begin
					ram_raddr = ent_q.next[SOCK_W-1:0];
					nstate = S_NB2_RD;
				end else begin
					emit = 1'b1;
					nstate = S_OUT;
				end
			end
			S_NB2_RD: begin
				// set prev of cur_q entry to ent_q.prev (delete) or sock (push)
				ram_we = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = ram_rdata;
				ram_wdata.prev = (mode_q == MODE_DEL) ? ent_q.prev : LINK_W'(sock_q);
				emit = 1'b1;
				nstate = S_OUT;
			end
			S_WAIT_RD: begin
				// ram_rdata is head entry (if any)
				emit = 1'b1;
				if (head_q == LINK_END || left_q == '0) begin
					nstate = S_OUT;
				end else begin
					fl_we = 1'b1;
					fl_waddr = hd;
					fl_reg_i = 1'b1;
					fl_rdy_i = 1'b0;
					emit_r.sock = hd;
					emit_r.events = ram_rdata.mask;
					emit_r.data = ram_rdata.data;
					emit_r.has = 1'b1;
					emit_r.last = (left_q == MAXE_W'(1)) ||
						(ram_rdata.next == LINK_END);
					if (ram_rdata.next != LINK_END) begin
						ram_raddr = ram_rdata.next[SOCK_W-1:0];
						nstate = S_WAIT_NB;
					end else nstate = S_OUT;
				end
			end
			S_WAIT_NB: begin
				ram_we = 1'b1;
				ram_waddr = hd;
				ram_wdata = ram_rdata;
				ram_wdata.prev = LINK_END;
				ram_raddr = hd;
				nstate = S_OUT;
			end
			S_OUT: begin
				ram_raddr = hd;
				if (ofree) nstate = ret_q;
			end
			default: nstate = S_IDLE;
		endcase
	end

	logic wait_more;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
			out_q <= '0;
			head_q <= LINK_END;
			rcount_q <= '0;
			regcount_q <= '0;
			ret_q <= S_IDLE;
			left_q <= '0;
		end else begin
			state_q <= nstate;
			if (emit) begin
				ovalid_q <= 1'b1;
				out_q <= emit_r;
				ret_q <= emit_r.last ? S_IDLE : S_WAIT_RD;
			end else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			if (acc)
				left_q <= (in_mode == MODE_WAIT && head_q == LINK_END) ? '0 : maxe_sat;
			// bookkeeping on list and counts
			if (state_q == S_RD && mode_q == MODE_ADD && !fl_reg)
				regcount_q <= regcount_q + CNT_W'(1);
			if (state_q == S_RD && mode_q == MODE_DEL && fl_reg) begin
				if (regcount_q != '0) regcount_q <= regcount_q - CNT_W'(1);
				if (fl_rdy) begin
					if (ram_rdata.prev == LINK_END) head_q <= ram_rdata.next;
					if (rcount_q != '0) rcount_q <= rcount_q - CNT_W'(1);
				end
			end
			if (state_q == S_RD && mode_q == MODE_NOTIFY && fl_reg && !fl_rdy) begin
				head_q <= LINK_W'(sock_q);
				rcount_q <= rcount_q + CNT_W'(1);
			end
			if (state_q == S_WAIT_RD && wait_more) begin
				head_q <= ram_rdata.next;
				left_q <= left_q - MAXE_W'(1);
				if (rcount_q != '0) rcount_q <= rcount_q - CNT_W'(1);
			end
		end
	end
	assign wait_more = head_q != LINK_END && left_q != '0;

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= in_mode;
			sock_q <= in_sock;
			ev_q <= s_axis_tdata[44:13];
			data_q <= s_axis_tdata[108:45];
		end
		if (state_q == S_RD) begin
			ent_q <= ram_rdata;
			cur_q <= (mode_q == MODE_DEL) ? ram_rdata.next[SOCK_W-1:0] : hd;
		end
	end
endmodule

/* rtl/ert_ram.sv */
module ert_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/ert_flags.sv */
// registered and ready flags, one bit each per socket, kept in a small ram
// a clearing pass after reset zeroes every entry
module ert_flags (
	input logic clk,
	input logic arst_n,
	output logic busy,
	input logic [ert_pkg::SOCK_W-1:0] raddr,
	output logic reg_o,
	output logic rdy_o,
	input logic we,
	input logic [ert_pkg::SOCK_W-1:0] waddr,
	input logic reg_i,
	input logic rdy_i
);
	import ert_pkg::*;
	logic clr_q;
	logic [SOCK_W-1:0] clr_addr_q;
	logic ram_we;
	logic [SOCK_W-1:0] ram_waddr;
	logic [1:0] ram_wdata, ram_rdata;

	// clearing pass walks every address once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + SOCK_W'(1);
			if (clr_addr_q == SOCK_W'(NUM_SOCKETS - 1)) clr_q <= 1'b0;
		end
	end
	assign busy = clr_q;

	always_comb begin
		ram_we = clr_q || we;
		ram_waddr = clr_q ? clr_addr_q : waddr;
		ram_wdata = clr_q ? 2'b00 : {reg_i, rdy_i};
	end

	// bit 1 registered, bit 0 ready
	ert_ram #(.WIDTH(2), .DEPTH(NUM_SOCKETS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(raddr), .rdata(ram_rdata)
	);
	assign reg_o = ram_rdata[1];
	assign rdy_o = ram_rdata[0];
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import ert_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic m_axis_tlast;

	event_ready_table_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// predicted table contents
	bit registered[NUM_SOCKETS];
	bit ready_mark[NUM_SOCKETS];
	logic [31:0] entry_mask[NUM_SOCKETS];
	logic [63:0] entry_data[NUM_SOCKETS];
	int ready_list[$];    // index 0 is the list head
	result_t expected_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int errors = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predict the results of one transfer and update the table copy
	task automatic predict_op(input logic [2:0] mode, input logic [9:0] sock,
			input logic [31:0] ev, input logic [63:0] data, input logic [6:0] maxe);
		result_t r;
		int num;
		int s;
		int idx[$];
		r = '0;
		r.last = 1'b1;
		case (mode)
			MODE_ADD: begin
				if (registered[sock]) begin
					r.status = ST_EXISTS;
				end else begin
					registered[sock] = 1'b1;
					ready_mark[sock] = 1'b0;
					entry_mask[sock] = ev;
					entry_data[sock] = data;
				end
				expected_results.push_back(r);
			end
			MODE_DEL: begin
				if (!registered[sock]) begin
					r.status = ST_NOREG;
				end else begin
					if (ready_mark[sock]) begin
						idx = ready_list.find_first_index(x) with (x == sock);
						ready_list.delete(idx[0]);
						ready_mark[sock] = 1'b0;
					end
					registered[sock] = 1'b0;
				end
				expected_results.push_back(r);
			end
			MODE_MOD: begin
				if (!registered[sock])
					r.status = ST_NOREG;
				else
					entry_mask[sock] = ev | EPOLLERR | EPOLLHUP;
				expected_results.push_back(r);
			end
			MODE_NOTIFY: begin
				if (!registered[sock]) begin
					r.status = ST_NOREG;
				end else if (ready_mark[sock]) begin
					entry_mask[sock] |= ev;
					r.status = ST_MERGED;
				end else begin
					ready_mark[sock] = 1'b1;
					ready_list.push_front(int'(sock));
				end
				expected_results.push_back(r);
			end
			MODE_WAIT: begin
				num = (maxe == 0) ? 1 : ((maxe > MAX_BURST) ? MAX_BURST : int'(maxe));
				if (num > ready_list.size())
					num = ready_list.size();
				if (num == 0)
					expected_results.push_back(r);
				for (int k = 0; k < num; k++) begin
					s = ready_list.pop_front();
					ready_mark[s] = 1'b0;
					r = '0;
					r.sock = SOCK_W'(s);
					r.events = entry_mask[s];
					r.data = entry_data[s];
					r.has = 1'b1;
					r.last = (k == num - 1);
					expected_results.push_back(r);
				end
			end
			default: begin
				// undefined modes just answer with an empty result
				expected_results.push_back(r);
			end
		endcase
	endtask

	// send one transfer, with random idle cycles before it
	task automatic send_op(input logic [2:0] mode, input logic [9:0] sock,
			input logic [31:0] ev, input logic [63:0] data, input logic [6:0] maxe);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		predict_op(mode, sock, ev, data, maxe);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, maxe, data, ev, sock, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rand_bits32();
		// a few corner masks mixed in with random ones
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// field extremes, every mode, merge, unlink of a mid-list entry, empty wait
	task automatic test_directed();
		send_op(MODE_WAIT, 10'd0, 32'h0, 64'h0, 7'd1);
		send_op(MODE_DEL, 10'd0, 32'h0, 64'h0, 7'd0);
		send_op(MODE_MOD, 10'd1023, 32'h0, 64'h0, 7'd0);
		send_op(MODE_NOTIFY, 10'd5, 32'hFFFF_FFFF, 64'h0, 7'd0);
		send_op(MODE_ADD, 10'd0, 32'h0, 64'h0, 7'd127);
		send_op(MODE_ADD, 10'd1023, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
		send_op(MODE_ADD, 10'd0, 32'h1, 64'h1, 7'd0);
		send_op(MODE_ADD, 10'd512, 32'h5555_AAAA, 64'h0123_4567_89AB_CDEF, 7'd64);
		send_op(MODE_MOD, 10'd0, 32'h0, 64'h0, 7'd0);
		send_op(MODE_NOTIFY, 10'd0, 32'h1, 64'h0, 7'd0);
		send_op(MODE_NOTIFY, 10'd512, 32'h2, 64'h0, 7'd0);
		send_op(MODE_NOTIFY, 10'd1023, 32'h4, 64'h0, 7'd0);
		send_op(MODE_NOTIFY, 10'd0, 32'h8000_0000, 64'h0, 7'd0);
		// remove the middle of the ready list
		send_op(MODE_DEL, 10'd512, 32'h0, 64'h0, 7'd0);
		send_op(3'd5, 10'd0, 32'h0, 64'h0, 7'd0);
		send_op(3'd7, 10'd1023, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		send_op(MODE_WAIT, 10'd0, 32'h0, 64'h0, 7'd0);
		send_op(MODE_WAIT, 10'd0, 32'h0, 64'h0, 7'd127);
		send_op(MODE_DEL, 10'd1023, 32'h0, 64'h0, 7'd0);
		send_op(MODE_DEL, 10'd0, 32'h0, 64'h0, 7'd0);
		send_op(MODE_WAIT, 10'd0, 32'h0, 64'h0, 7'd64);
	endtask

	// mostly valid sequences on a small socket pool, plus wide random noise
	task automatic test_random(input int n_items);
		logic [9:0] sock;
		logic [2:0] mode;
		int pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 85)
				sock = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) :
					10'($urandom_range(15) * 64 + $urandom_range(1));
			else
				sock = 10'($urandom);
			pick = $urandom_range(99);
			if (pick < 22) mode = MODE_ADD;
			else if (pick < 34) mode = MODE_DEL;
			else if (pick < 44) mode = MODE_MOD;
			else if (pick < 78) mode = MODE_NOTIFY;
			else if (pick < 96) mode = MODE_WAIT;
			else mode = 3'($urandom_range(7, 5));
			send_op(mode, sock, rand_bits32(), rand64(),
				($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(6, 1)));
		end
	endtask

	// make 65 sockets ready so a wait returns a full burst, then wait again
	task automatic test_full_burst();
		for (int i = 0; i < 65; i++)
			if (!registered[i + 100])
				send_op(MODE_ADD, 10'(i + 100), $urandom, rand64(), 7'd0);
		for (int i = 0; i < 65; i++)
			send_op(MODE_NOTIFY, 10'(i + 100), $urandom, 64'h0, 7'd0);
		send_op(MODE_WAIT, 10'd0, 32'h0, 64'h0, 7'd127);
		send_op(MODE_WAIT, 10'd0, 32'h0, 64'h0, 7'd64);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// result check: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{status: m_axis_tdata[1:0], sock: m_axis_tdata[11:2],
				events: m_axis_tdata[43:12], data: m_axis_tdata[107:44],
				has: m_axis_tdata[108], last: m_axis_tlast};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.sock !== want.sock) begin
					$display("%0t: out_sock exp %0d got %0d", $time, want.sock, got.sock);
					errors++;
				end
				if (got.events !== want.events) begin
					$display("%0t: out_events exp %h got %h", $time, want.events, got.events);
					errors++;
				end
				if (got.data !== want.data) begin
					$display("%0t: out_data exp %h got %h", $time, want.data, got.data);
					errors++;
				end
				if (got.has !== want.has) begin
					$display("%0t: has_entry exp %b got %b", $time, want.has, got.has);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: tlast exp %b got %b", $time, want.last, got.last);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 23;
		recv_idle_pct = 88;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		for (int i = 0; i < NUM_SOCKETS; i++) begin
			registered[i] = 1'b0;
			ready_mark[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(10);
		send_idle_pct = 88;
		recv_idle_pct = 23;
		test_random(10);
		test_full_burst();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(10);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
